// ===== design/abtd_pkg.sv =====
// ----------------------------------------------------------------------------
// abtd_pkg
// Shared types and constants for the affine block transposition decryptor.
// ----------------------------------------------------------------------------
`default_nettype none

package abtd_pkg;

  localparam int MAX_BLOCK = 64;
  localparam int ADDR_W    = $clog2(MAX_BLOCK);
  localparam int CNT_W     = ADDR_W + 1;

  localparam logic [7:0] PAD_BYTE = 8'h20;

  localparam logic [1:0] CFG_BLOCK_LEN  = 2'd0;
  localparam logic [1:0] CFG_MULTIPLIER = 2'd1;
  localparam logic [1:0] CFG_OFFSET     = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_KEY,
    S_EMIT
  } ctl_state_t;

  typedef enum logic [1:0] {
    K_IDLE,
    K_MOD,
    K_SEARCH
  } key_state_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] n;
    logic [7:0]       a;
    logic [7:0]       b;
  } key_req_t;

  typedef struct packed {
    logic              done;
    logic              err;
    logic [ADDR_W-1:0] inv;
    logic [ADDR_W-1:0] ioff;
  } key_rsp_t;

endpackage

`default_nettype wire

// ===== design/affine_block_transposition_decrypt.sv =====
// ----------------------------------------------------------------------------
// affine_block_transposition_decrypt
// Collects ciphertext bytes into a block buffer and emits each block in
// affine-transposed order.
// ----------------------------------------------------------------------------
// Input: a byte transfers at a rising edge with start high and busy low.
// A byte that neither fills the block nor ends the message leaves busy low,
// and the next byte may follow at once.
// A byte that completes the block or ends the message raises busy while
// the key unit runs: it reduces multiplier and offset mod n, then searches
// for the inverse, then hands over the result. A bad key gives one result
// with key_error set, registered at the output. Otherwise the block is read
// back from the buffer one entry per cycle, and each read passes through the
// buffer's read data register and the output register before it appears as
// a result. No new byte is taken until the last entry of the block has been
// read.
// Results: out_valid marks each result for exactly one cycle; the receiver
// cannot stall, so no result is held back.
// Configuration: cfg_we writes register cfg_index with cfg_wdata at once.
// Reset: rst_n clears the fill count and returns all control to idle; the
// buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_block_transposition_decrypt (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] in_cipher_byte,
  input  wire logic       in_message_end,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  output logic            out_valid,
  output logic [7:0]      out_plain_byte,
  output logic            out_block_last,
  output logic            out_message_last,
  output logic            out_key_error
);
  import abtd_pkg::*;

  ctl_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  blk_len_r;
  logic [7:0]        mult_r, offs_r;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]  lim_r, nlen_r;
  logic              end_r;
  logic [ADDR_W-1:0] j_r, k_r;
  logic              s1_valid_r, s1_pad_r, s1_last_r, s1_mlast_r;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_blast_r, out_blast_nxt;
  logic              out_mlast_r, out_mlast_nxt;
  logic              out_kerr_r, out_kerr_nxt;

  logic [CNT_W-1:0]  n_eff, fill_inc, k_sum, k_red;
  logic              accept, emit_go, wr_en, issue, last_j, err_out;
  logic [7:0]        rd_data;
  key_req_t          key_req;
  key_rsp_t          key_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_len_r <= CNT_W'(8);
      mult_r    <= 8'd1;
      offs_r    <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_LEN:  blk_len_r <= cfg_wdata[CNT_W-1:0];
        CFG_MULTIPLIER: mult_r    <= cfg_wdata;
        CFG_OFFSET:     offs_r    <= cfg_wdata;
        default:        blk_len_r <= blk_len_r;
      endcase
    end
  end

  always_comb begin
    if (blk_len_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (blk_len_r > CNT_W'(MAX_BLOCK)) begin
      n_eff = CNT_W'(MAX_BLOCK);
    end else begin
      n_eff = blk_len_r;
    end
    accept   = start && (state_r == S_IDLE);
    wr_en    = accept && !fill_r[CNT_W-1];
    fill_inc = fill_r + {{(CNT_W-1){1'b0}}, !fill_r[CNT_W-1]};
    emit_go  = accept && ((fill_inc >= n_eff) || in_message_end);
    fill_nxt = fill_r;
    if (accept) begin
      fill_nxt = emit_go ? '0 : fill_inc;
    end
    key_req.start = emit_go;
    key_req.n     = n_eff;
    key_req.a     = mult_r;
    key_req.b     = offs_r;
    last_j  = ({1'b0, j_r} == nlen_r - CNT_W'(1));
    k_sum   = {1'b0, k_r} + {1'b0, key_rsp.inv};
    k_red   = (k_sum >= nlen_r) ? k_sum - nlen_r : k_sum;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (emit_go) begin
          state_nxt = S_KEY;
        end
      end
      S_KEY: begin
        if (key_rsp.done) begin
          state_nxt = key_rsp.err ? S_IDLE : S_EMIT;
        end
      end
      S_EMIT: begin
        if (last_j) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy    = (state_r != S_IDLE);
    issue   = (state_r == S_EMIT);
    err_out = (state_r == S_KEY) && key_rsp.done && key_rsp.err;
    out_valid_nxt = s1_valid_r || err_out;
    out_kerr_nxt  = err_out;
    out_blast_nxt = err_out || s1_last_r;
    out_mlast_nxt = err_out ? end_r : s1_mlast_r;
    if (err_out) begin
      out_byte_nxt = 8'd0;
    end else if (s1_pad_r) begin
      out_byte_nxt = PAD_BYTE;
    end else begin
      out_byte_nxt = rd_data;
    end
  end

  abtd_buf u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r[ADDR_W-1:0]),
    .wr_data (in_cipher_byte),
    .rd_en   (issue),
    .rd_addr (k_r),
    .rd_data (rd_data)
  );

  abtd_key u_key (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (key_req),
    .rsp   (key_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      s1_valid_r  <= issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      lim_r  <= fill_inc;
      nlen_r <= n_eff;
      end_r  <= in_message_end;
    end
    if (state_r == S_KEY && key_rsp.done) begin
      j_r <= '0;
      k_r <= key_rsp.ioff;
    end else if (issue) begin
      j_r <= j_r + ADDR_W'(1);
      k_r <= k_red[ADDR_W-1:0];
    end
    s1_pad_r    <= ({1'b0, k_r} >= lim_r);
    s1_last_r   <= last_j;
    s1_mlast_r  <= last_j && end_r;
    out_byte_r  <= out_byte_nxt;
    out_blast_r <= out_blast_nxt;
    out_mlast_r <= out_mlast_nxt;
    out_kerr_r  <= out_kerr_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_plain_byte   = out_byte_r;
  assign out_block_last   = out_blast_r;
  assign out_message_last = out_mlast_r;
  assign out_key_error    = out_kerr_r;

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_error |-> out_block_last && out_plain_byte == 8'd0)
    else $error("key error result malformed");

  a_mlast_blast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_last |-> out_block_last)
    else $error("message end without block end");

  a_done_in_key: assert property (@(posedge clk) disable iff (!rst_n)
    key_rsp.done |-> state_r == S_KEY)
    else $error("key unit finished outside key phase");

  a_emit_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |=> !(out_valid && out_key_error))
    else $error("key error during block emission");

endmodule

`default_nettype wire

// ===== design/abtd_buf.sv =====
// ----------------------------------------------------------------------------
// abtd_buf
// Block buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module abtd_buf (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [abtd_pkg::ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]                wr_data,
  input  wire logic                      rd_en,
  input  wire logic [abtd_pkg::ADDR_W-1:0] rd_addr,
  output logic      [7:0]                rd_data
);
  import abtd_pkg::*;

  logic [7:0] mem [MAX_BLOCK];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== design/abtd_key.sv =====
// ----------------------------------------------------------------------------
// abtd_key
// Key unit: reduces the keys mod n bit by bit, then searches the inverse of
// the multiplier and derives the inverse offset.
// ----------------------------------------------------------------------------
`default_nettype none

module abtd_key (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire abtd_pkg::key_req_t req,
  output abtd_pkg::key_rsp_t      rsp
);
  import abtd_pkg::*;

  key_state_t        state_r, state_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [7:0]        a_sh_r, a_sh_nxt;
  logic [7:0]        b_sh_r, b_sh_nxt;
  logic              a_zero_r, a_zero_nxt;
  logic [ADDR_W-1:0] ra_r, ra_nxt;
  logic [ADDR_W-1:0] rb_r, rb_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [ADDR_W-1:0] r_r, r_nxt;
  logic [ADDR_W-1:0] p_r, p_nxt;
  key_rsp_t          rsp_r, rsp_nxt;

  logic [CNT_W-1:0]  sa, sb, ra_red, rb_red;
  logic [CNT_W-1:0]  r_sum, p_sum, r_red, p_red;
  logic [CNT_W-1:0]  neg_p;

  always_comb begin
    sa     = {ra_r, a_sh_r[7]};
    sb     = {rb_r, b_sh_r[7]};
    ra_red = (sa >= n_r) ? sa - n_r : sa;
    rb_red = (sb >= n_r) ? sb - n_r : sb;
    r_sum  = {1'b0, r_r} + {1'b0, ra_r};
    p_sum  = {1'b0, p_r} + {1'b0, rb_r};
    r_red  = (r_sum >= n_r) ? r_sum - n_r : r_sum;
    p_red  = (p_sum >= n_r) ? p_sum - n_r : p_sum;
    neg_p  = n_r - {1'b0, p_r};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      K_IDLE: begin
        if (req.start) begin
          state_nxt = K_MOD;
        end
      end
      K_MOD: begin
        if (cnt_r == 3'd7) begin
          state_nxt = K_SEARCH;
        end
      end
      K_SEARCH: begin
        if (n_r == CNT_W'(1) || i_r == n_r || r_r == ADDR_W'(1)) begin
          state_nxt = K_IDLE;
        end
      end
      default: state_nxt = K_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    n_nxt      = n_r;
    a_sh_nxt   = a_sh_r;
    b_sh_nxt   = b_sh_r;
    a_zero_nxt = a_zero_r;
    ra_nxt     = ra_r;
    rb_nxt     = rb_r;
    i_nxt      = i_r;
    r_nxt      = r_r;
    p_nxt      = p_r;
    rsp_nxt    = rsp_r;
    rsp_nxt.done = 1'b0;
    case (state_r)
      K_IDLE: begin
        if (req.start) begin
          cnt_nxt    = 3'd0;
          n_nxt      = req.n;
          a_sh_nxt   = req.a;
          b_sh_nxt   = req.b;
          a_zero_nxt = (req.a == 8'd0);
          ra_nxt     = '0;
          rb_nxt     = '0;
        end
      end
      K_MOD: begin
        cnt_nxt  = cnt_r + 3'd1;
        a_sh_nxt = {a_sh_r[6:0], 1'b0};
        b_sh_nxt = {b_sh_r[6:0], 1'b0};
        ra_nxt   = ra_red[ADDR_W-1:0];
        rb_nxt   = rb_red[ADDR_W-1:0];
        i_nxt    = CNT_W'(1);
        r_nxt    = ra_red[ADDR_W-1:0];
        p_nxt    = rb_red[ADDR_W-1:0];
      end
      K_SEARCH: begin
        if (n_r == CNT_W'(1)) begin
          rsp_nxt.done = 1'b1;
          rsp_nxt.err  = a_zero_r;
          rsp_nxt.inv  = '0;
          rsp_nxt.ioff = '0;
        end else if (i_r == n_r) begin
          rsp_nxt.done = 1'b1;
          rsp_nxt.err  = 1'b1;
        end else if (r_r == ADDR_W'(1)) begin
          rsp_nxt.done = 1'b1;
          rsp_nxt.err  = 1'b0;
          rsp_nxt.inv  = i_r[ADDR_W-1:0];
          rsp_nxt.ioff = (p_r == '0) ? '0 : neg_p[ADDR_W-1:0];
        end else begin
          i_nxt = i_r + CNT_W'(1);
          r_nxt = r_red[ADDR_W-1:0];
          p_nxt = p_red[ADDR_W-1:0];
        end
      end
      default: begin
        rsp_nxt.done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= K_IDLE;
      rsp_r.done   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rsp_r.done   <= rsp_nxt.done;
    end
    cnt_r      <= cnt_nxt;
    n_r        <= n_nxt;
    a_sh_r     <= a_sh_nxt;
    b_sh_r     <= b_sh_nxt;
    a_zero_r   <= a_zero_nxt;
    ra_r       <= ra_nxt;
    rb_r       <= rb_nxt;
    i_r        <= i_nxt;
    r_r        <= r_nxt;
    p_r        <= p_nxt;
    rsp_r.err  <= rsp_nxt.err;
    rsp_r.inv  <= rsp_nxt.inv;
    rsp_r.ioff <= rsp_nxt.ioff;
  end

  assign rsp = rsp_r;

endmodule

`default_nettype wire

// ===== tb/abtd_decrypt_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abtd_decrypt_check
// Watches the byte, result and register ports of the affine block
// transposition decryptor, predicts every plaintext result from its own copy
// of the block buffer and key registers, and compares each result transfer
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module abtd_decrypt_check (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic       busy,
  input  wire logic [7:0] in_cipher_byte,
  input  wire logic       in_message_end,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       out_valid,
  input  wire logic [7:0] out_plain_byte,
  input  wire logic       out_block_last,
  input  wire logic       out_message_last,
  input  wire logic       out_key_error,
  output int unsigned     fail_count,
  output int unsigned     pending_count,
  output int unsigned     result_count,
  output int unsigned     key_error_count
);
  import abtd_pkg::*;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       block_last;
    logic       message_last;
    logic       key_error;
  } plain_result_t;

  plain_result_t expected_plain[$];

  logic [7:0]  block_store [MAX_BLOCK];
  int unsigned fill_q;
  logic [6:0]  blen_q;
  logic [7:0]  mult_q;
  logic [7:0]  off_q;

  task automatic predict_block_byte(input logic [7:0] cb, input logic me);
    int unsigned   n;
    int unsigned   inv;
    int unsigned   ioff;
    int unsigned   k;
    int unsigned   x;
    int unsigned   y;
    int unsigned   t;
    plain_result_t r;
    n = 32'(blen_q);
    if (n == 0) n = 1;
    if (n > MAX_BLOCK) n = MAX_BLOCK;
    if (fill_q < MAX_BLOCK) begin
      block_store[fill_q] = cb;
      fill_q++;
    end
    if (fill_q < n && !me) return;
    for (int unsigned j = fill_q; j < n; j++) block_store[j] = PAD_BYTE;
    fill_q = 0;
    x = 32'(mult_q);
    y = n;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    if (mult_q == 8'd0 || x != 1) begin
      r = '{plain_byte: 8'h00, block_last: 1'b1, message_last: me, key_error: 1'b1};
      expected_plain.push_back(r);
      return;
    end
    inv = 0;
    for (int unsigned i = 1; i < n; i++) begin
      if ((i * 32'(mult_q)) % n == 1) begin
        inv = i;
        break;
      end
    end
    ioff = (n - (inv * 32'(off_q)) % n) % n;
    for (int unsigned j = 0; j < n; j++) begin
      k = (inv * j + ioff) % n;
      r.plain_byte   = block_store[k];
      r.block_last   = (j + 1 == n);
      r.message_last = (j + 1 == n) && me;
      r.key_error    = 1'b0;
      expected_plain.push_back(r);
    end
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    plain_result_t want;
    result_count++;
    if (out_key_error) key_error_count++;
    if (expected_plain.size() == 0) begin
      $error("plain_byte %0h arrived with no result pending", out_plain_byte);
      fail_count++;
    end else begin
      want = expected_plain.pop_front();
      compare_field("plain_byte", 32'(want.plain_byte), 32'(out_plain_byte));
      compare_field("block_last", 32'(want.block_last), 32'(out_block_last));
      compare_field("message_last", 32'(want.message_last), 32'(out_message_last));
      compare_field("key_error", 32'(want.key_error), 32'(out_key_error));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_plain.delete();
      fill_q          = 0;
      blen_q          = 7'd8;
      mult_q          = 8'd1;
      off_q           = 8'd0;
      fail_count      = 0;
      result_count    = 0;
      key_error_count = 0;
    end else begin
      if (out_valid) check_result();
      if (cfg_we) begin
        case (cfg_index)
          CFG_BLOCK_LEN:  blen_q = cfg_wdata[6:0];
          CFG_MULTIPLIER: mult_q = cfg_wdata;
          CFG_OFFSET:     off_q  = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) predict_block_byte(in_cipher_byte, in_message_end);
    end
    pending_count = expected_plain.size();
  end

endmodule

// ===== tb/affine_block_transposition_decrypt_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_block_transposition_decrypt_test
// Drives ciphertext messages and key settings into the decryptor: a short
// directed set covering padding, full-block message ends, lengths one and zero, bad
// keys and a block length lowered mid-block, then random messages over many
// key settings with varying sender gaps. A separate checker predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module affine_block_transposition_decrypt_test;
  import abtd_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [7:0] in_cipher_byte;
  logic       in_message_end;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;
  logic       out_valid;
  logic [7:0] out_plain_byte;
  logic       out_block_last;
  logic       out_message_last;
  logic       out_key_error;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned result_count;
  int unsigned key_error_count;

  int unsigned idle_pct;
  int unsigned items_sent;
  int unsigned settings_used;

  affine_block_transposition_decrypt uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cipher_byte   (in_cipher_byte),
    .in_message_end   (in_message_end),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_plain_byte   (out_plain_byte),
    .out_block_last   (out_block_last),
    .out_message_last (out_message_last),
    .out_key_error    (out_key_error)
  );

  abtd_decrypt_check decrypt_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cipher_byte   (in_cipher_byte),
    .in_message_end   (in_message_end),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_plain_byte   (out_plain_byte),
    .out_block_last   (out_block_last),
    .out_message_last (out_message_last),
    .out_key_error    (out_key_error),
    .fail_count       (fail_count),
    .pending_count    (pending_count),
    .result_count     (result_count),
    .key_error_count  (key_error_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned gcd_of(input int unsigned x, input int unsigned y);
    int unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Transfer one byte; called and returns at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic e);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start          <= 1'b1;
    in_cipher_byte <= b;
    in_message_end <= e;
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_message(input int unsigned len, input logic with_end);
    for (int unsigned k = 0; k < len; k++)
      send_byte(8'($urandom_range(255)), with_end && (k + 1 == len));
  endtask

  // Hold off until every predicted result has arrived and the block is quiet.
  task automatic drain();
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic configure(input logic [7:0] len_w, input logic [7:0] mult_w,
                           input logic [7:0] off_w);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BLOCK_LEN;
    cfg_wdata <= len_w;
    @(negedge clk);
    cfg_index <= CFG_MULTIPLIER;
    cfg_wdata <= mult_w;
    @(negedge clk);
    cfg_index <= CFG_OFFSET;
    cfg_wdata <= off_w;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [7:0]  first_block [8];
    int unsigned idle_pattern [3];
    logic [7:0]  len_w;
    logic [7:0]  mult_w;
    logic [7:0]  off_w;
    int unsigned n_eff;
    int unsigned r;
    int unsigned phase;
    int unsigned phase_items;
    int unsigned msg_len;

    first_block  = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};
    idle_pattern = '{0, 81, 18};
    idle_pct       = 0;
    items_sent     = 0;
    settings_used  = 0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_cipher_byte = 8'h00;
    in_message_end = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_BLOCK_LEN;
    cfg_wdata      = 8'h00;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset keys, message ends exactly on a full block.
    foreach (first_block[i]) send_byte(first_block[i], i == 7);
    drain();
    // Partial block padded with spaces, offset above n.
    configure(8'h85, 8'd3, 8'd7);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h43, 1'b1);
    drain();
    // Length one passes bytes straight through.
    configure(8'd1, 8'd200, 8'd255);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b1);
    drain();
    // Zero multiplier.
    configure(8'd1, 8'd0, 8'd0);
    send_byte(8'h99, 1'b1);
    drain();
    // Multiplier sharing a factor with n.
    configure(8'd6, 8'd4, 8'd1);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b1);
    drain();
    // Lower block length with five bytes already held.
    configure(8'd10, 8'd3, 8'd1);
    for (int unsigned i = 0; i < 5; i++) send_byte(8'(8'hD0 + i), 1'b0);
    drain();
    configure(8'd3, 8'd3, 8'd1);
    send_byte(8'hE5, 1'b0);
    drain();
    // Block length zero acts as one.
    configure(8'h80, 8'd255, 8'd0);
    send_byte(8'h5A, 1'b1);
    drain();

    phase = 0;
    while (items_sent < 400) begin
      idle_pct = idle_pattern[phase % 3];
      r = $urandom_range(99);
      if (r < 8) len_w = 8'd0;
      else if (r < 16) len_w = 8'd64;
      else if (r < 24) len_w = 8'($urandom_range(65, 127));
      else if (r < 40) len_w = 8'($urandom_range(13, 63));
      else len_w = 8'($urandom_range(1, 12));
      n_eff = 32'(len_w[6:0]);
      if (n_eff == 0) n_eff = 1;
      if (n_eff > MAX_BLOCK) n_eff = MAX_BLOCK;
      len_w[7] = 1'($urandom_range(1));
      if ($urandom_range(99) < 75) begin
        do mult_w = 8'($urandom_range(1, 255)); while (gcd_of(32'(mult_w), n_eff) != 1);
      end else begin
        mult_w = 8'($urandom_range(255));
      end
      off_w = 8'($urandom_range(255));
      configure(len_w, mult_w, off_w);
      phase_items = 0;
      while (phase_items < 30) begin
        msg_len = $urandom_range(1, n_eff + n_eff / 2 + 1);
        send_message(msg_len, 1'b1);
        phase_items += msg_len;
        if ($urandom_range(99) < 10) drain();
      end
      // Sometimes leave a message open so the next setting can land mid-block.
      if ($urandom_range(99) < 30) send_message($urandom_range(1, n_eff), 1'b0);
      drain();
      phase++;
    end

    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("Sent %0d ciphertext bytes under %0d key settings; checked %0d results",
             items_sent, settings_used, result_count);
    $display("(%0d key errors), with sender gaps of 0, 18 and 81 percent.",
             key_error_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
